// ===== rtl/phmt_pkg.sv =====
`default_nettype none
package phmt_pkg;

  // table geometry
  localparam int PEER_SLOTS = 32;
  localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W      = $clog2(PEER_SLOTS + 1);

  // field widths
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 64;
  localparam int TIME_W  = 63;
  localparam int TO_W    = 48;
  localparam int MISS_W  = 8;
  localparam int STATE_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_MISSES = 1'd1;
  localparam logic [TO_W-1:0]   TIMEOUT_RESET = 48'd3000000000;
  localparam logic [MISS_W-1:0] OFFLINE_RESET = 8'd3;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_PING = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PONG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] RK_REPLY  = 2'd0;
  localparam logic [KIND_W-1:0] RK_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] RK_END    = 2'd2;

  // peer states
  localparam logic [STATE_W-1:0] PS_UNKNOWN = 2'd0;
  localparam logic [STATE_W-1:0] PS_ONLINE  = 2'd1;
  localparam logic [STATE_W-1:0] PS_SUSPECT = 2'd2;
  localparam logic [STATE_W-1:0] PS_OFFLINE = 2'd3;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // fixed offline threshold for ping/pong replies
  localparam logic [MISS_W-1:0] REPLY_OFFLINE_MISSES = 8'd3;
  localparam logic [MISS_W-1:0] MISS_MAX = 8'd255;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  peer_key;
    logic [TIME_W-1:0] now;
  } hb_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [KEY_W-1:0]   peer_key_out;
    logic [STATE_W-1:0] peer_state;
    logic [MISS_W-1:0]  miss_count;
    logic               status;
    logic               last;
  } hb_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } hb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic scan_last;
  } hb_stat_t;

  function automatic logic [MISS_W-1:0] sat_inc(input logic [MISS_W-1:0] m);
    sat_inc = (m == MISS_MAX) ? MISS_MAX : m + 8'd1;
  endfunction

  function automatic logic [STATE_W-1:0] reply_state(input logic [MISS_W-1:0] m);
    if (m >= REPLY_OFFLINE_MISSES) reply_state = PS_OFFLINE;
    else if (m != '0)              reply_state = PS_SUSPECT;
    else                           reply_state = PS_ONLINE;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/peer_heartbeat_miss_tracker_core.sv =====
`default_nettype none
// Sequencing: each ping, pong or tick walks the table over the read port at one
// slot a cycle while the output register is not blocked, then finishes with its
// final result in the output register; expiry results appear during the walk.
// The block takes no new item until the current one has finished.
// Reset (rst, synchronous): clears the table valid bits, the controller and the
// output register, and restores ping_timeout to 3000000000 and offline_misses to 3.
module peer_heartbeat_miss_tracker_core import phmt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire hb_in_t                in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output hb_out_t                    out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  hb_cmd_t  cmd;
  hb_stat_t stat;

  assign cfg_ready = 1'b1;

  phmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  phmt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a real item transaction makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.kind != KIND_NONE) |=> in_stall)
    else $error("block not busy after item transaction");

  // expiry results only exist while a tick is being walked
  a_expiry_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == RK_EXPIRY) |-> (in_stall && !out_data.last))
    else $error("expiry result outside of a tick walk");

  // when idle, any pending result is the final one of its item
  a_idle_final: assert property (@(posedge clk) disable iff (rst)
    (!in_stall && out_valid) |-> out_data.last)
    else $error("idle with a non-final result pending");

  // the walk never runs while the output register is blocked
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> (!out_valid || !out_stall))
    else $error("walk advanced into a stalled output");

endmodule
`default_nettype wire

// ===== rtl/phmt_ctrl.sv =====
`default_nettype none
module phmt_ctrl import phmt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_stall,
  input  wire hb_stat_t          stat,
  output hb_cmd_t                cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // sequencing: take item, walk the table, then finish
  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.finish  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = accept;
        if (accept && in_kind != KIND_NONE) state_next = S_SCAN;
      end
      S_SCAN: begin
        // hold the walk while an expiry result cannot be placed
        cmd.advance = stat.out_free;
        if (stat.out_free && stat.scan_last) state_next = S_POST;
      end
      S_POST: begin
        cmd.finish = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// ===== rtl/phmt_datapath.sv =====
`default_nettype none
module phmt_datapath import phmt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hb_in_t                in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire hb_cmd_t               cmd,
  output hb_stat_t                   stat,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output hb_out_t                    out_data
);

  // configuration
  logic [TO_W-1:0]   timeout;
  logic [MISS_W-1:0] offline_misses;

  // held item
  hb_in_t item;

  // peer table
  logic [PEER_SLOTS-1:0] valid;
  logic [KEY_W-1:0]      mem_key  [PEER_SLOTS];
  logic [TIME_W-1:0]     mem_time [PEER_SLOTS];
  logic [MISS_W-1:0]     mem_miss [PEER_SLOTS];

  // walk pipeline
  logic [CNT_W-1:0]  rd_idx;
  logic              chk_vld;
  logic [SLOT_W-1:0] chk_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [TIME_W-1:0] rd_time;
  logic [MISS_W-1:0] rd_miss;

  // lookup results for ping/pong
  logic              found;
  logic [SLOT_W-1:0] found_slot;
  logic [MISS_W-1:0] found_miss;
  logic              free_ok;
  logic [SLOT_W-1:0] free_slot;

  logic              is_tick;
  logic              rd_in_range;
  logic              chk_valid_bit;
  logic [TIME_W:0]   diff;
  logic              expired;
  logic              key_hit;
  logic [MISS_W-1:0] exp_miss;
  logic [MISS_W-1:0] pp_miss;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [KEY_W-1:0]  mem_wkey;
  logic [MISS_W-1:0] mem_wmiss;
  logic              exp_emit;
  logic              out_load;
  hb_out_t           out_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout        <= TIMEOUT_RESET;
      offline_misses <= OFFLINE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PING_TIMEOUT)   timeout <= cfg_data[TO_W-1:0];
      if (cfg_index == CFG_OFFLINE_MISSES) offline_misses <= cfg_data[MISS_W-1:0];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
  end

  // checks on the slot in the compare stage
  assign is_tick       = (item.kind == KIND_TICK);
  assign rd_in_range   = (rd_idx < CNT_W'(PEER_SLOTS));
  assign chk_valid_bit = valid[chk_idx];
  assign diff          = {1'b0, item.now} - {1'b0, rd_time};
  assign expired       = chk_vld && chk_valid_bit && (rd_miss != '0) && !diff[TIME_W] &&
                         (diff[TIME_W-1:0] > {(TIME_W - TO_W)'(0), timeout});
  assign key_hit       = chk_vld && chk_valid_bit && (rd_key == item.peer_key);
  assign exp_miss      = sat_inc(rd_miss);
  assign exp_emit      = cmd.advance && is_tick && expired;

  always_comb begin
    if (item.kind == KIND_PING) pp_miss = found ? sat_inc(found_miss) : 8'd1;
    else                        pp_miss = '0;
  end

  // single write port shared by tick expiry and ping/pong update
  assign mem_we    = exp_emit || (cmd.finish && !is_tick && (found || free_ok));
  assign mem_wa    = is_tick ? chk_idx : (found ? found_slot : free_slot);
  assign mem_wkey  = is_tick ? rd_key : item.peer_key;
  assign mem_wmiss = is_tick ? exp_miss : pp_miss;

  // table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[mem_wa]  <= mem_wkey;
      mem_time[mem_wa] <= item.now;
      mem_miss[mem_wa] <= mem_wmiss;
    end
    if (cmd.advance && rd_in_range) begin
      rd_key  <= mem_key[rd_idx[SLOT_W-1:0]];
      rd_time <= mem_time[rd_idx[SLOT_W-1:0]];
      rd_miss <= mem_miss[rd_idx[SLOT_W-1:0]];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (cmd.finish && !is_tick && !found && free_ok) valid[free_slot] <= 1'b1;
  end

  // walk counters and lookup tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      chk_vld <= 1'b0;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      chk_vld <= 1'b0;
      found   <= 1'b0;
      free_ok <= 1'b0;
    end else if (cmd.advance) begin
      chk_vld <= rd_in_range;
      if (rd_in_range) rd_idx <= rd_idx + CNT_W'(1);
      if (!is_tick) begin
        if (key_hit && !found) found <= 1'b1;
        if (chk_vld && !chk_valid_bit && !free_ok) free_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      chk_idx <= rd_idx[SLOT_W-1:0];
      if (!is_tick && key_hit && !found) begin
        found_slot <= chk_idx;
        found_miss <= rd_miss;
      end
      if (!is_tick && chk_vld && !chk_valid_bit && !free_ok) free_slot <= chk_idx;
    end
  end

  assign stat.scan_last = (rd_idx == CNT_W'(PEER_SLOTS));
  assign stat.out_free  = !out_valid || !out_stall;

  // result selection
  assign out_load = exp_emit || cmd.finish;

  always_comb begin
    out_next.result_kind  = RK_EXPIRY;
    out_next.peer_key_out = rd_key;
    out_next.peer_state   = (exp_miss >= offline_misses) ? PS_OFFLINE : PS_SUSPECT;
    out_next.miss_count   = exp_miss;
    out_next.status       = STATUS_OK;
    out_next.last         = 1'b0;
    if (cmd.finish) begin
      out_next.last = 1'b1;
      if (is_tick) begin
        out_next.result_kind  = RK_END;
        out_next.peer_key_out = '0;
        out_next.peer_state   = PS_UNKNOWN;
        out_next.miss_count   = '0;
      end else if (found || free_ok) begin
        out_next.result_kind  = RK_REPLY;
        out_next.peer_key_out = item.peer_key;
        out_next.peer_state   = reply_state(pp_miss);
        out_next.miss_count   = pp_miss;
      end else begin
        out_next.result_kind  = RK_REPLY;
        out_next.peer_key_out = item.peer_key;
        out_next.peer_state   = PS_UNKNOWN;
        out_next.miss_count   = '0;
        out_next.status       = STATUS_FULL;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
  end

endmodule
`default_nettype wire
